// ===== hw/rtl/skd_pkg.sv =====
// shared types and constants for the silence keep-alive detector
package skd_pkg;

   // default build parameters
   localparam int SKD_MAX_CHANNELS = 8;
   localparam int SKD_SAMPLE_BITS  = 16;

   // register and field widths
   localparam int THR_W  = 16;
   localparam int TMO_W  = 20;
   localparam int NCH_W  = 4;
   localparam int CNT_W  = 20;
   localparam int CSR_W  = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // register reset values
   localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(33);
   localparam logic [TMO_W-1:0] TIMEOUT_RST   = TMO_W'(60000);
   localparam logic [NCH_W-1:0] CHANNELS_RST  = NCH_W'(2);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THRESHOLD = 2'd0,
      REG_TIMEOUT   = 2'd1,
      REG_CHANNELS  = 2'd2
   } skd_reg_type;

   // item kinds on the request tuser
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } skd_op_type;

   // result payload, first member in the highest bits
   typedef struct packed {
      logic [CNT_W-1:0] silence_ms;
      logic             last_frame_sound;
      logic             batch_had_sound;
      logic             triggered;
   } skd_result_type;

   localparam int RESULT_W    = $bits(skd_result_type);
   localparam int RSP_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== hw/rtl/skd_out_buf.sv =====
// two-entry result buffer: output register plus skid register
module skd_out_buf
   import skd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  skd_result_type push_data,
   output logic           push_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output skd_result_type out_data
);

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   skd_result_type out_data_ff, out_data_in;
   skd_result_type skid_data_ff, skid_data_in;
   logic           out_load;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;
   assign out_load   = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_load) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_data_in   = push_data;
            out_valid_in  = push;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         // output stalled, park the new item
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== hw/rtl/silence_keepalive_detector.sv =====
// top level of the silence keep-alive detector
// an accepted item's result is registered into the output buffer for rsp_tvalid
// throughput: one item per cycle while the result buffer has room; the state
//   update is a single compare and counter step registered at the accepting edge
// a two-entry result buffer keeps req_tready high while one result waits
// reset is synchronous and active high: registers return to their defaults
//   and all detector state clears
module silence_keepalive_detector
   import skd_pkg::*;
#(
   parameter int MAX_CHANNELS = SKD_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = SKD_SAMPLE_BITS,
   localparam int REQ_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // sample, zero padded
   input  logic                   req_tuser,   // op
   input  logic                   req_tlast,   // last_in_batch
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // triggered, batch_had_sound, last_frame_sound, silence_ms, zero padded
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   // channel position width and a compare width that holds the clamped count
   localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NW0   = $clog2(MAX_CHANNELS + 1);
   localparam int NW    = (NW0 > NCH_W) ? NW0 : NCH_W;
   // magnitude compare width
   localparam int MW    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   // configuration registers
   logic [THR_W-1:0] threshold_ff;
   logic [TMO_W-1:0] timeout_ff;
   logic [NCH_W-1:0] channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         timeout_ff   <= TIMEOUT_RST;
         channels_ff  <= CHANNELS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            REG_TIMEOUT:   timeout_ff   <= csr_wdata[TMO_W-1:0];
            REG_CHANNELS:  channels_ff  <= csr_wdata[NCH_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // detector state
   logic             batch_sound_ff, batch_sound_in;
   logic             frame_nz_ff, frame_nz_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             last_frame_ff, last_frame_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic                   accept;
   logic                   buf_ready;
   skd_result_type         result;
   skd_result_type         rsp_data;

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   nonzero;
   logic                   sound;
   logic [NW-1:0]          n_ch;
   logic [NW-1:0]          pos_next;
   logic                   batch_sound_new;
   logic                   frame_nz_new;

   assign req_tready = buf_ready;
   assign accept     = req_tvalid && buf_ready;

   assign raw     = req_tdata[SAMPLE_BITS-1:0];
   assign nonzero = (raw != '0);
   // two's complement magnitude, most negative value reads as full scale
   assign mag     = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

   // zero threshold selects the any-nonzero mode
   assign sound = (threshold_ff == '0) ? nonzero
                                      : (MW'(mag) >= MW'(threshold_ff));

   // clamp the channel count into one to max channels
   always_comb begin
      n_ch = NW'(channels_ff);
      if (n_ch == '0) begin
         n_ch = NW'(1);
      end else if (n_ch > NW'(MAX_CHANNELS)) begin
         n_ch = NW'(MAX_CHANNELS);
      end
   end

   assign pos_next        = NW'(pos_ff) + NW'(1);
   assign batch_sound_new = batch_sound_ff || sound;
   assign frame_nz_new    = (pos_ff == '0) ? nonzero : (frame_nz_ff || nonzero);

   always_comb begin
      batch_sound_in = batch_sound_ff;
      frame_nz_in    = frame_nz_ff;
      pos_in         = pos_ff;
      last_frame_in  = last_frame_ff;
      cnt_in         = cnt_ff;
      result.triggered       = 1'b0;
      result.batch_had_sound = 1'b0;

      unique case (skd_op_type'(req_tuser))
         OP_TICK: begin
            // saturating ms counter
            if (cnt_ff != CNT_MAX) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OP_SAMPLE: begin
            batch_sound_in = batch_sound_new;
            frame_nz_in    = frame_nz_new;
            // wrap as soon as the position reaches the count
            pos_in = (pos_next >= n_ch) ? '0 : pos_next[POS_W-1:0];
            if (req_tlast) begin
               last_frame_in          = frame_nz_new;
               result.batch_had_sound = batch_sound_new;
               if (batch_sound_new) begin
                  cnt_in = '0;
               end else if (CNT_W'(timeout_ff) <= cnt_ff) begin
                  // silent long enough, fire keep-alive
                  result.triggered = 1'b1;
                  cnt_in           = '0;
               end
               // next batch starts clean
               batch_sound_in = 1'b0;
               frame_nz_in    = 1'b0;
               pos_in         = '0;
            end
         end
         default: ;
      endcase

      result.last_frame_sound = last_frame_in;
      result.silence_ms       = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_sound_ff <= 1'b0;
         frame_nz_ff    <= 1'b0;
         pos_ff         <= '0;
         last_frame_ff  <= 1'b0;
         cnt_ff         <= '0;
      end else if (accept) begin
         batch_sound_ff <= batch_sound_in;
         frame_nz_ff    <= frame_nz_in;
         pos_ff         <= pos_in;
         last_frame_ff  <= last_frame_in;
         cnt_ff         <= cnt_in;
      end
   end

   // result register with skid entry
   skd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (buf_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_data)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RESULT_W){1'b0}}, rsp_data};

endmodule

// ===== bench/tb_silence_keepalive_detector.sv =====
// testbench for the silence keep-alive detector: directed and random items checked by a local model
`timescale 1ns / 100ps
module tb_silence_keepalive_detector;
   import skd_pkg::*;

   localparam int SMP_W         = SKD_SAMPLE_BITS;
   localparam int REQ_W         = ((SMP_W + 7) / 8) * 8;
   localparam int CHAN_LIMIT    = SKD_MAX_CHANNELS;
   // settle time waited once every predicted report has come back
   localparam int SETTLE_CYCLES = 3;
   localparam int RANDOM_ITEMS  = 1600;

   // block inputs, all known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tready = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_W-1:0]       csr_wdata  = '0;

   // block outputs
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // idling on both channels is allowed while this is set
   bit                     idling_on = 1'b0;
   int unsigned            fail_count = 0;
   int unsigned            stall_left = 0;

   // reports predicted for accepted items, oldest first
   skd_result_type         silence_reports_due[$];
   skd_result_type         seen_report;
   skd_result_type         due_report;

   // local copy of the registers
   logic [THR_W-1:0]       mdl_threshold;
   logic [TMO_W-1:0]       mdl_timeout;
   logic [NCH_W-1:0]       mdl_channels;

   // local copy of the detector state
   bit                     sound_in_batch;
   bit                     nonzero_in_frame;
   bit                     final_frame_nonzero;
   int unsigned            frame_slot;
   logic [CNT_W-1:0]       quiet_ms;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   silence_keepalive_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // sample
      .req_tuser  (req_tuser),    // op
      .req_tlast  (req_tlast),    // last_in_batch
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // triggered, batch_had_sound, last_frame_sound, silence_ms
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic void reset_detector_model();
      mdl_threshold       = THRESHOLD_RST;
      mdl_timeout         = TIMEOUT_RST;
      mdl_channels        = CHANNELS_RST;
      sound_in_batch      = 1'b0;
      nonzero_in_frame    = 1'b0;
      final_frame_nonzero = 1'b0;
      frame_slot          = 0;
      quiet_ms            = '0;
   endfunction

   // one item through the detector model, returns the report it causes
   function automatic skd_result_type advance_detector(skd_op_type op, logic [SMP_W-1:0] smp,
                                                       logic lst);
      skd_result_type rpt;
      logic [SMP_W:0] mag;
      bit             nonzero;
      bit             sound;
      int unsigned    frame_len;
      rpt = '0;
      if (op == OP_TICK) begin
         // saturating millisecond count, tick data and last mark ignored
         if (quiet_ms != CNT_MAX) quiet_ms = quiet_ms + 1'b1;
      end else begin
         nonzero = (smp != '0);
         // sign extend one bit so the most negative sample has a true magnitude
         mag = {smp[SMP_W-1], smp};
         if (smp[SMP_W-1]) mag = -mag;
         if (mdl_threshold == '0) sound = nonzero;
         else sound = (mag >= {1'b0, mdl_threshold});
         // channel count clamped to one and to the build maximum
         if (mdl_channels == '0) frame_len = 1;
         else if (mdl_channels > CHAN_LIMIT) frame_len = CHAN_LIMIT;
         else frame_len = mdl_channels;
         sound_in_batch = sound_in_batch || sound;
         if (frame_slot == 0) nonzero_in_frame = nonzero;
         else nonzero_in_frame = nonzero_in_frame || nonzero;
         frame_slot = (frame_slot + 1 >= frame_len) ? 0 : frame_slot + 1;
         if (lst) begin
            final_frame_nonzero   = nonzero_in_frame;
            rpt.batch_had_sound = sound_in_batch;
            if (sound_in_batch) begin
               quiet_ms = '0;
            end else if (quiet_ms >= mdl_timeout) begin
               rpt.triggered = 1'b1;
               quiet_ms      = '0;
            end
            sound_in_batch   = 1'b0;
            nonzero_in_frame = 1'b0;
            frame_slot       = 0;
         end
      end
      rpt.last_frame_sound = final_frame_nonzero;
      rpt.silence_ms       = quiet_ms;
      return rpt;
   endfunction

   // sample mix: many zeros and values near small thresholds, full range, extremes
   function automatic logic [SMP_W-1:0] pick_sample();
      logic [SMP_W-1:0] smp;
      case ($urandom_range(0, 9))
         0, 1: smp = '0;
         2, 3, 4: begin
            smp = SMP_W'($urandom_range(0, 80));
            if ($urandom_range(0, 1) == 1) smp = -smp;
         end
         5, 6, 7: smp = SMP_W'($urandom);
         8: smp = {1'b1, {(SMP_W-1){1'b0}}};
         default: smp = ($urandom_range(0, 1) == 1) ? {1'b0, {(SMP_W-1){1'b1}}} : '1;
      endcase
      return smp;
   endfunction

   // sender: optional idle burst, then hold the item until it is taken
   task automatic send_item(input skd_op_type op, input logic [SMP_W-1:0] smp,
                            input logic lst);
      bit took;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= op;
      req_tlast  <= lst;
      // ready is judged at the falling edge, where every input has settled
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      silence_reports_due.push_back(advance_detector(op, smp, lst));
   endtask

   // stop sending and hold until every predicted report has come back
   task automatic wait_for_results();
      int unsigned waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (silence_reports_due.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (silence_reports_due.size() != 0) begin
         $error("%0d predicted reports never arrived", silence_reports_due.size());
         fail_count++;
         silence_reports_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all three registers on back to back cycles; only called while idle
   task automatic configure(input logic [CSR_W-1:0] thr_raw, input logic [CSR_W-1:0] tmo_raw,
                            input logic [CSR_W-1:0] ch_raw);
      csr_we    <= 1'b1;
      csr_index <= REG_THRESHOLD;
      csr_wdata <= thr_raw;
      @(posedge clock);
      csr_index <= REG_TIMEOUT;
      csr_wdata <= tmo_raw;
      @(posedge clock);
      csr_index <= REG_CHANNELS;
      csr_wdata <= ch_raw;
      @(posedge clock);
      csr_we <= 1'b0;
      mdl_threshold = thr_raw[THR_W-1:0];
      mdl_timeout   = tmo_raw[TMO_W-1:0];
      mdl_channels  = ch_raw[NCH_W-1:0];
   endtask

   // receiver: ready drops in random bursts while idling is allowed
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // report checker, sampled at the falling edge ahead of the accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_report = skd_result_type'(rsp_tdata[RESULT_W-1:0]);
         if (silence_reports_due.size() == 0) begin
            $error("report with no item pending: %h", seen_report);
            fail_count++;
         end else begin
            due_report = silence_reports_due.pop_front();
            if (seen_report.triggered !== due_report.triggered) begin
               $error("triggered: expected %0d, got %0d",
                      due_report.triggered, seen_report.triggered);
               fail_count++;
            end
            if (seen_report.batch_had_sound !== due_report.batch_had_sound) begin
               $error("batch_had_sound: expected %0d, got %0d",
                      due_report.batch_had_sound, seen_report.batch_had_sound);
               fail_count++;
            end
            if (seen_report.last_frame_sound !== due_report.last_frame_sound) begin
               $error("last_frame_sound: expected %0d, got %0d",
                      due_report.last_frame_sound, seen_report.last_frame_sound);
               fail_count++;
            end
            if (seen_report.silence_ms !== due_report.silence_ms) begin
               $error("silence_ms: expected %0d, got %0d",
                      due_report.silence_ms, seen_report.silence_ms);
               fail_count++;
            end
         end
      end
   end

   // reset settings: threshold edge on both signs, a quiet batch below the timeout
   task automatic test_default_threshold();
      send_item(OP_SAMPLE, SMP_W'(32), 1'b0);
      send_item(OP_SAMPLE, SMP_W'(-33), 1'b1);
      send_item(OP_TICK, '1, 1'b1);
      send_item(OP_SAMPLE, SMP_W'(-32), 1'b0);
      send_item(OP_SAMPLE, '0, 1'b1);
   endtask

   // zero threshold counts any nonzero sample; zero timeout fires on every quiet batch
   task automatic test_nonzero_mode();
      wait_for_results();
      configure('0, '0, CSR_W'(3));
      send_item(OP_SAMPLE, '0, 1'b0);
      send_item(OP_SAMPLE, '0, 1'b0);
      send_item(OP_SAMPLE, '0, 1'b1);
      // batch ending on a partial frame
      send_item(OP_SAMPLE, SMP_W'(1), 1'b1);
      // leave the frame partly full for the channel change that follows
      send_item(OP_SAMPLE, {1'b1, {(SMP_W-1){1'b0}}}, 1'b0);
      send_item(OP_SAMPLE, '0, 1'b0);
   endtask

   // full scale threshold: only the most negative sample reaches it
   task automatic test_full_scale_threshold();
      wait_for_results();
      // channel count shrinks mid-frame, position wraps on the next sample
      configure(CSR_W'(32768), CSR_W'(2), CSR_W'(1));
      send_item(OP_SAMPLE, {1'b0, {(SMP_W-1){1'b1}}}, 1'b1);
      send_item(OP_TICK, '0, 1'b0);
      send_item(OP_TICK, '0, 1'b0);
      send_item(OP_SAMPLE, {1'b1, {(SMP_W-1){1'b0}}}, 1'b1);
      send_item(OP_TICK, '0, 1'b0);
      send_item(OP_TICK, '0, 1'b0);
      send_item(OP_SAMPLE, '0, 1'b1);
   endtask

   // zero and oversize channel counts, thresholds above full scale, wide writes
   task automatic test_channel_clamp();
      wait_for_results();
      // upper write bits beyond each register are dropped
      configure('1, CSR_W'(1), {{(CSR_W-NCH_W){1'b1}}, {NCH_W{1'b0}}});
      send_item(OP_TICK, '0, 1'b0);
      send_item(OP_SAMPLE, {1'b1, {(SMP_W-1){1'b0}}}, 1'b1);
      wait_for_results();
      configure(CSR_W'(32769), CSR_W'(600000), CSR_W'(15));
      // eight nonzero samples fill one clamped frame, the zero opens a new one
      repeat (CHAN_LIMIT) send_item(OP_SAMPLE, SMP_W'(-1), 1'b0);
      send_item(OP_SAMPLE, '0, 1'b1);
   endtask

   // random settings per segment, mostly well formed batches with ticks mixed in
   task automatic test_random_traffic();
      int unsigned      sent;
      int unsigned      seg_sent;
      int unsigned      seg_len;
      int unsigned      batch_len;
      int unsigned      tick_odds;
      bit               broken;
      logic [CSR_W-1:0] thr;
      logic [CSR_W-1:0] tmo;
      logic [CSR_W-1:0] ch;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // sender pause: registers change only once every report is back
         wait_for_results();
         case ($urandom_range(0, 6))
            0: thr = '0;
            1, 2: thr = CSR_W'($urandom_range(1, 64));
            3: thr = CSR_W'($urandom);
            4: thr = CSR_W'(32768);
            5: thr = CSR_W'(32767);
            default: thr = CSR_W'(16'hFFFF);
         endcase
         case ($urandom_range(0, 5))
            0: tmo = '0;
            1, 2, 3: tmo = CSR_W'($urandom_range(1, 40));
            4: tmo = CSR_W'($urandom_range(1, 600000));
            default: tmo = CSR_W'($urandom);
         endcase
         ch = ($urandom_range(0, 3) == 0) ? CSR_W'($urandom) : CSR_W'($urandom_range(0, 15));
         configure(thr, tmo, ch);
         idling_on = ($urandom_range(0, 3) != 0);
         tick_odds = $urandom_range(0, 60);
         seg_len   = $urandom_range(100, 190);
         seg_sent  = 0;
         while (seg_sent < seg_len) begin
            batch_len = $urandom_range(1, 3 * CHAN_LIMIT);
            // some batches run on with no last mark and merge into the next
            broken = ($urandom_range(0, 7) == 0);
            for (int unsigned i = 0; i < batch_len; i++) begin
               if ($urandom_range(0, 99) < tick_odds) begin
                  send_item(OP_TICK, SMP_W'($urandom), 1'($urandom));
                  seg_sent++;
               end
               send_item(OP_SAMPLE, pick_sample(), (i == batch_len - 1) && !broken);
               seg_sent++;
            end
         end
         sent += seg_sent;
      end
   endtask

   // the largest timeout, run with no idling at all
   task automatic test_largest_timeout();
      wait_for_results();
      idling_on = 1'b0;
      configure(CSR_W'(33), '1, CSR_W'(2));
      repeat (40) send_item(OP_TICK, SMP_W'($urandom), 1'($urandom));
      send_item(OP_SAMPLE, SMP_W'(32), 1'b0);
      // quiet batch far below the timeout, no keep-alive
      send_item(OP_SAMPLE, '0, 1'b1);
      send_item(OP_TICK, '0, 1'b0);
      send_item(OP_SAMPLE, SMP_W'(-200), 1'b1);
   endtask

   initial begin
      reset_detector_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_threshold();
      test_nonzero_mode();
      test_full_scale_threshold();
      test_channel_clamp();
      test_random_traffic();
      test_largest_timeout();
      wait_for_results();
      if (fail_count == 0) begin
         $display("silence_keepalive_detector verification clean");
      end else begin
         $display("silence_keepalive_detector verification failed");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #3ms;
      $display("silence_keepalive_detector verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/skd_pkg.sv
hw/rtl/skd_out_buf.sv
hw/rtl/silence_keepalive_detector.sv
bench/tb_silence_keepalive_detector.sv
